[design/pidst_pkg.sv]
// pidst_pkg: shared types and codes for the packed id set table
// transaction structs, command and status codes, and the per-cell control group
// no dependencies

package pidst_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    localparam int KEY_BITS   = 32;
    localparam int INDEX_BITS = 4;
    localparam int COUNT_BITS = 5;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [KEY_BITS-1:0]   key;
        logic [INDEX_BITS-1:0] index;
    } t_in;

    typedef struct packed {
        logic [1:0]            status;
        logic [INDEX_BITS-1:0] position;
        logic [KEY_BITS-1:0]   entry_value;
        logic [COUNT_BITS-1:0] live_count;
    } t_out;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic match_en;
        logic add_en;
        logic shift_en;
    } t_cell_ctl;

endpackage

[design/pidst_cell.sv]
// pidst_cell: one slot of the packed id set table
// holds one key, registers its compare result, shifts in its neighbor on delete
// depends on pidst_pkg

module pidst_cell #(
    parameter int W   = 32,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  pidst_pkg::t_cell_ctl                i_ctl,
    input  logic [W-1:0]                        i_key,
    input  logic [W-1:0]                        i_next_key,
    input  logic [CW-1:0]                       i_count,
    input  logic [pidst_pkg::INDEX_BITS-1:0]    i_rd_idx,
    input  logic                                i_hit,
    output logic                                o_hit,
    output logic                                o_first,
    output logic [W-1:0]                        o_key,
    output logic [W-1:0]                        o_rd_val
);

    localparam bit RD_REACH = (IDX < (1 << pidst_pkg::INDEX_BITS));

    logic [W-1:0] r_key;
    logic         r_match;
    logic         live;
    logic         rd_sel;

    assign live   = (CW'(IDX) < i_count);
    assign rd_sel = RD_REACH && (i_rd_idx == pidst_pkg::INDEX_BITS'(IDX));

    always_ff @(posedge i_clk) begin
        if (i_ctl.match_en) begin
            r_match <= live && (r_key == i_key);
        end
        if (i_ctl.add_en && (i_count == CW'(IDX))) begin
            r_key <= i_key;
        end else if (i_ctl.shift_en && o_hit) begin
            // at or past the deleted slot: pull the neighbor down
            r_key <= i_next_key;
        end
    end

    assign o_hit    = i_hit | r_match;
    assign o_first  = r_match & ~i_hit;
    assign o_key    = r_key;
    assign o_rd_val = rd_sel ? r_key : '0;

endmodule

[design/pidst_chain.sv]
// pidst_chain: the row of table cells with the match chain between neighbors
// gathers first-match position, found flag and the read value
// depends on pidst_pkg and pidst_cell

module pidst_chain #(
    parameter int CAPACITY = 16,
    parameter int W        = 32,
    parameter int CW       = 5
) (
    input  logic                                i_clk,
    input  pidst_pkg::t_cell_ctl                i_ctl,
    input  logic [W-1:0]                        i_key,
    input  logic [CW-1:0]                       i_count,
    input  logic [pidst_pkg::INDEX_BITS-1:0]    i_rd_idx,
    output logic                                o_found,
    output logic [pidst_pkg::INDEX_BITS-1:0]    o_pos,
    output logic [W-1:0]                        o_rd_val
);

    logic [CAPACITY:0]   hit;
    logic [CAPACITY-1:0] first;
    logic [W-1:0]        cell_key [CAPACITY];
    logic [W-1:0]        rd_val   [CAPACITY];

    assign hit[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [W-1:0] next_key;
        if (g == CAPACITY - 1) begin : g_last
            assign next_key = cell_key[g];
        end else begin : g_mid
            assign next_key = cell_key[g+1];
        end

        pidst_cell #(
            .W   (W),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_key      (i_key),
            .i_next_key (next_key),
            .i_count    (i_count),
            .i_rd_idx   (i_rd_idx),
            .i_hit      (hit[g]),
            .o_hit      (hit[g+1]),
            .o_first    (first[g]),
            .o_key      (cell_key[g]),
            .o_rd_val   (rd_val[g])
        );
    end

    assign o_found = hit[CAPACITY];

    always_comb begin
        o_pos    = '0;
        o_rd_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first[i]) begin
                o_pos = o_pos | pidst_pkg::INDEX_BITS'(i);
            end
            o_rd_val = o_rd_val | rd_val[i];
        end
    end

endmodule

[design/packed_id_set_table.sv]
// packed_id_set_table: packed key list with live count, add/delete/search/read
// the compare is registered in the cells at the accepting edge, the result at the end of apply
// compare then apply in the cell row: no new transaction is accepted until the apply cycle ends
// a stalled result holds the block in its apply cycle until the output register frees
// reset clears the count and handshake state; stored keys are not cleared
// depends on pidst_pkg and pidst_chain

module packed_id_set_table #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pidst_pkg::t_in    i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pidst_pkg::t_out   o_out
);

    localparam int W  = (KEY_WIDTH < pidst_pkg::KEY_BITS) ? KEY_WIDTH : pidst_pkg::KEY_BITS;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WORK = 1'b1;

    logic                              r_state, n_state;
    logic [CW-1:0]                     r_count, n_count;
    logic [1:0]                        r_cmd;
    logic [W-1:0]                      r_key;
    logic [pidst_pkg::INDEX_BITS-1:0]  r_idx;
    logic                              r_out_valid, n_out_valid;
    pidst_pkg::t_out                   r_out, n_out;

    logic                              accept;
    logic                              apply_done;
    logic [W-1:0]                      key_bus;
    pidst_pkg::t_cell_ctl              ctl;
    logic                              found;
    logic [pidst_pkg::INDEX_BITS-1:0]  pos;
    logic [W-1:0]                      rd_val;
    logic                              full;
    logic                              rd_ok;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign apply_done = (r_state == S_WORK) && (!r_out_valid || !i_out_stall);

    // compare uses the incoming key, the add write uses the held one
    assign key_bus = accept ? i_in.key[W-1:0] : r_key;

    assign full  = (r_count >= CW'(CAPACITY));
    assign rd_ok = ({{CW{1'b0}}, r_idx} < {{pidst_pkg::INDEX_BITS{1'b0}}, r_count});

    always_comb begin
        ctl.match_en = accept;
        ctl.add_en   = apply_done && (r_cmd == pidst_pkg::CMD_ADD) && !full;
        ctl.shift_en = apply_done && (r_cmd == pidst_pkg::CMD_DELETE);
    end

    pidst_chain #(
        .CAPACITY (CAPACITY),
        .W        (W),
        .CW       (CW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_key    (key_bus),
        .i_count  (r_count),
        .i_rd_idx (r_idx),
        .o_found  (found),
        .o_pos    (pos),
        .o_rd_val (rd_val)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (apply_done) begin
                    n_state            = S_IDLE;
                    n_out_valid        = 1'b1;
                    n_out.status       = pidst_pkg::ST_OK;
                    n_out.position     = '0;
                    n_out.entry_value  = '0;
                    case (r_cmd)
                        pidst_pkg::CMD_ADD: begin
                            if (full) begin
                                n_out.status = pidst_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        pidst_pkg::CMD_DELETE: begin
                            if (found) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_out.status = pidst_pkg::ST_ABSENT;
                            end
                        end
                        pidst_pkg::CMD_SEARCH: begin
                            if (found) begin
                                n_out.position = pos;
                            end else begin
                                n_out.status = pidst_pkg::ST_ABSENT;
                            end
                        end
                        default: begin
                            if (rd_ok) begin
                                n_out.entry_value = pidst_pkg::KEY_BITS'(rd_val);
                            end else begin
                                n_out.status = pidst_pkg::ST_ABSENT;
                            end
                        end
                    endcase
                    n_out.live_count = pidst_pkg::COUNT_BITS'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_cmd <= i_in.cmd;
            r_key <= i_in.key[W-1:0];
            r_idx <= i_in.index;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("live count above capacity");

    a_result_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(apply_done))
        else $error("result appeared without an apply cycle");

    a_count_moves_on_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(apply_done))
        else $error("count changed outside an apply cycle");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_WORK))
        else $error("accepted transaction did not start work");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for packed_id_set_table
// predicts every result from its own copy of the key list and count, checks field by field
// depends on pidst_pkg and the packed_id_set_table rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH    = 16;
    localparam int MAX_WAIT       = 18;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            i_out_stall = 1'b0;
    pidst_pkg::t_in  i_in        = '0;
    logic            o_in_stall;
    logic            o_out_valid;
    pidst_pkg::t_out o_out;

    // shadow of the table contents
    logic [pidst_pkg::KEY_BITS-1:0] table_keys [TABLE_DEPTH];
    int                             table_count = 0;
    logic [pidst_pkg::KEY_BITS-1:0] key_pool [8];

    pidst_pkg::t_out pending_results [$];
    int   error_count   = 0;
    int   idle_cycles   = 0;
    int   gap_limit     = MAX_WAIT;
    bit   in_valid_high = 1'b0;

    packed_id_set_table #(
        .CAPACITY  (TABLE_DEPTH),
        .KEY_WIDTH (pidst_pkg::KEY_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // applies one command to the shadow table and returns the result it must produce
    function automatic pidst_pkg::t_out apply_table_command(input pidst_pkg::t_in item);
        pidst_pkg::t_out res;
        int              hit;
        res = '0;
        res.status = pidst_pkg::ST_OK;
        hit = -1;
        for (int i = 0; i < table_count; i++) begin
            if (hit < 0 && table_keys[i] == item.key) hit = i;
        end
        case (item.cmd)
            pidst_pkg::CMD_ADD: begin
                if (table_count >= TABLE_DEPTH) begin
                    res.status = pidst_pkg::ST_FULL;
                end else begin
                    table_keys[table_count] = item.key;
                    table_count++;
                end
            end
            pidst_pkg::CMD_DELETE: begin
                if (hit < 0) begin
                    res.status = pidst_pkg::ST_ABSENT;
                end else begin
                    for (int i = hit; i < table_count - 1; i++) table_keys[i] = table_keys[i + 1];
                    table_count--;
                end
            end
            pidst_pkg::CMD_SEARCH: begin
                if (hit < 0) res.status = pidst_pkg::ST_ABSENT;
                else res.position = pidst_pkg::INDEX_BITS'(hit);
            end
            default: begin
                if (int'(item.index) < table_count) res.entry_value = table_keys[item.index];
                else res.status = pidst_pkg::ST_ABSENT;
            end
        endcase
        res.live_count = pidst_pkg::COUNT_BITS'(table_count);
        return res;
    endfunction

    // sends one transaction; valid stays high until a pause in a later call or wait_until_empty lowers it
    task automatic send_command(input logic [1:0] cmd,
                                input logic [pidst_pkg::KEY_BITS-1:0] key,
                                input logic [pidst_pkg::INDEX_BITS-1:0] index);
        pidst_pkg::t_in item;
        int             gap;
        item.cmd   = cmd;
        item.key   = key;
        item.index = index;
        gap = $urandom_range(0, gap_limit);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            in_valid_high = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        in_valid_high = 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_table_command(item));
    endtask

    task automatic wait_until_empty();
        if (in_valid_high) begin
            i_in_valid <= 1'b0;
            in_valid_high = 1'b0;
        end
        do @(posedge i_clk); while (pending_results.size() > 0);
    endtask

    // output side stall pattern, one draw per transaction
    initial begin : out_stall_driver
        int hold;
        @(posedge i_clk);
        forever begin
            hold = $urandom_range(0, gap_limit);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin
        pidst_pkg::t_out expected;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: %p", o_out);
                error_count++;
            end else begin
                expected = pending_results.pop_front();
                if (o_out.status !== expected.status) begin
                    $error("status: expected %0d, got %0d", expected.status, o_out.status);
                    error_count++;
                end
                if (o_out.position !== expected.position) begin
                    $error("position: expected %0d, got %0d", expected.position,
                           o_out.position);
                    error_count++;
                end
                if (o_out.entry_value !== expected.entry_value) begin
                    $error("entry_value: expected %h, got %h", expected.entry_value,
                           o_out.entry_value);
                    error_count++;
                end
                if (o_out.live_count !== expected.live_count) begin
                    $error("live_count: expected %0d, got %0d", expected.live_count,
                           o_out.live_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_command(pidst_pkg::CMD_READ, 32'h0, 4'd0);
        send_command(pidst_pkg::CMD_SEARCH, 32'h0, 4'd0);
        send_command(pidst_pkg::CMD_DELETE, 32'hFFFF_FFFF, 4'd15);
    endtask

    // fill with extreme and duplicate keys, overflow once, then delete and read at the ends
    task automatic test_fill_and_shift();
        send_command(pidst_pkg::CMD_ADD, 32'h0000_0000, 4'd0);
        send_command(pidst_pkg::CMD_ADD, 32'hFFFF_FFFF, 4'd15);
        send_command(pidst_pkg::CMD_ADD, 32'hA5A5_5A5A, 4'd0);
        for (int i = 3; i < TABLE_DEPTH - 1; i++) begin
            send_command(pidst_pkg::CMD_ADD, $urandom(), 4'(i));
        end
        send_command(pidst_pkg::CMD_ADD, 32'hA5A5_5A5A, 4'd0);
        send_command(pidst_pkg::CMD_ADD, 32'h1234_5678, 4'd0);
        send_command(pidst_pkg::CMD_SEARCH, 32'hA5A5_5A5A, 4'd0);
        send_command(pidst_pkg::CMD_DELETE, 32'hA5A5_5A5A, 4'd0);
        send_command(pidst_pkg::CMD_DELETE, 32'hA5A5_5A5A, 4'd0);
        send_command(pidst_pkg::CMD_READ, 32'h0, 4'd15);
        send_command(pidst_pkg::CMD_READ, 32'h0, 4'd13);
    endtask

    function automatic logic [pidst_pkg::KEY_BITS-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && table_count > 0) return table_keys[$urandom_range(0, table_count - 1)];
        if (r < 8) return key_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // add and delete shares steer the count toward full or empty
    task automatic test_random_mix(input int items, input int add_pct, input int del_pct);
        int         r;
        logic [1:0] cmd;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) cmd = pidst_pkg::CMD_ADD;
            else if (r < add_pct + del_pct) cmd = pidst_pkg::CMD_DELETE;
            else if (r % 2 == 0) cmd = pidst_pkg::CMD_SEARCH;
            else cmd = pidst_pkg::CMD_READ;
            send_command(cmd, pick_key(), 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_back_to_back(input int items);
        gap_limit = 0;
        test_random_mix(items, 35, 30);
        gap_limit = MAX_WAIT;
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_fill_and_shift();
        wait_until_empty();
        test_random_mix(400, 55, 15);
        test_random_mix(350, 15, 55);
        test_back_to_back(300);
        wait_until_empty();
        test_random_mix(400, 35, 30);
        test_random_mix(250, 70, 10);
        test_back_to_back(125);

        wait_until_empty();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
design/pidst_pkg.sv
design/pidst_cell.sv
design/pidst_chain.sv
design/packed_id_set_table.sv
tb/tb_top.sv
